[design/sfp_pkg.sv]
// package for the sensor frame parser
// buffer sizing, start bytes, phase and status codes; no dependencies

package sfp_pkg;

  // byte buffer size of the frame store
  localparam int BufBytes  = 32;
  localparam int BufWords  = BufBytes / 2;
  localparam int WordAw    = $clog2(BufWords);
  // accepted length field never exceeds buffer plus checksum, nor sixteen words
  localparam int LenCapRaw = (BufBytes + 2 < 34) ? BufBytes + 2 : 34;
  localparam logic [5:0] LenCap = 6'(LenCapRaw);

  localparam logic [7:0] StartA = 8'h42;
  localparam logic [7:0] StartB = 8'h4D;

  // parser phases
  localparam logic [2:0] PH_HUNT_A = 3'd0;
  localparam logic [2:0] PH_HUNT_B = 3'd1;
  localparam logic [2:0] PH_LEN_HI = 3'd2;
  localparam logic [2:0] PH_LEN_LO = 3'd3;
  localparam logic [2:0] PH_DATA   = 3'd4;
  localparam logic [2:0] PH_CHK_HI = 3'd5;
  localparam logic [2:0] PH_CHK_LO = 3'd6;
  localparam logic [2:0] PH_EMIT   = 3'd7;

  // result status codes
  localparam logic [1:0] ST_WORD   = 2'd0;
  localparam logic [1:0] ST_CSUM   = 2'd1;
  localparam logic [1:0] ST_BADLEN = 2'd2;

endpackage

[design/sfp_word_ram.sv]
// frame data store: one write port, one registered read port
// depends on sfp_pkg for depth and address width

module sfp_word_ram (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [sfp_pkg::WordAw-1:0] waddr_i,
  input  logic [15:0]               wdata_i,
  input  logic                      re_i,
  input  logic [sfp_pkg::WordAw-1:0] raddr_i,
  output logic [15:0]               rdata_o
);
  import sfp_pkg::*;

  logic [15:0] mem_q [BufWords];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/sensor_frame_parser_core.sv]
// sensor frame parser top level: byte hunt, length check, checksum, word output
// depends on sfp_pkg and sfp_word_ram
// latency: an error result is registered and presented in the cycle after the byte that causes it
// a good frame presents its first word through the store read register and the output register,
// then one word per cycle (up to 16) while the output is not stalled, set by the single read port of the word store
// throughput: one byte per cycle outside word output while the output is free; input stalls while words drain
// reset: async active low, returns to hunting, sum and counters zero, max_length 28

module sensor_frame_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,
  // byte input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [3:0]  word_index_o,
  output logic [15:0] word_value_o,
  output logic        last_o
);
  import sfp_pkg::*;

  // control state
  logic [2:0]  phase_q, phase_d;
  logic [5:0]  max_len_q;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  chk_hi_q, chk_hi_d;     // received checksum high byte
  logic [7:0]  len_hi_q, len_hi_d;
  logic [5:0]  data_len_q, data_len_d;
  logic [5:0]  byte_cnt_q, byte_cnt_d;
  logic [7:0]  hi_byte_q, hi_byte_d;   // pending high byte of the current word
  logic [3:0]  em_idx_q, em_idx_d;     // word held in the read register
  logic [4:0]  em_words_q, em_words_d;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [1:0]  out_status_q, out_status_d;
  logic [3:0]  out_idx_q, out_idx_d;
  logic [15:0] out_value_q, out_value_d;
  logic        out_last_q, out_last_d;

  // word store access
  logic              ram_we, ram_re;
  logic [WordAw-1:0] ram_waddr, ram_raddr;
  logic [15:0]       ram_wdata, ram_rdata;

  logic        in_acc, out_free;
  logic [5:0]  len_limit;
  logic        len_ok;
  logic [6:0]  words_sum;
  logic        last_byte;
  logic        em_last;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (phase_q == PH_EMIT) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  // effective length limit and check of the full 16-bit length field
  assign len_limit = (max_len_q > LenCap) ? LenCap : max_len_q;
  assign len_ok    = (len_hi_q == 8'h00) && (data_byte_i >= 8'd2)
                     && (data_byte_i <= {2'b00, len_limit});

  assign words_sum = {1'b0, data_len_q} + 7'd1;
  assign last_byte = (byte_cnt_q + 6'd1) == data_len_q;
  assign em_last   = ({1'b0, em_idx_q} + 5'd1) == em_words_q;

  always_comb begin
    phase_d      = phase_q;
    sum_d        = sum_q;
    chk_hi_d     = chk_hi_q;
    len_hi_d     = len_hi_q;
    data_len_d   = data_len_q;
    byte_cnt_d   = byte_cnt_q;
    hi_byte_d    = hi_byte_q;
    em_idx_d     = em_idx_q;
    em_words_d   = em_words_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_idx_d    = out_idx_q;
    out_value_d  = out_value_q;
    out_last_d   = out_last_q;
    ram_we       = 1'b0;
    ram_waddr    = byte_cnt_q[WordAw:1];
    ram_wdata    = {hi_byte_q, data_byte_i};
    ram_re       = 1'b0;
    ram_raddr    = '0;

    if (in_acc) begin
      case (phase_q)
        PH_HUNT_B: begin
          if (data_byte_i == StartB) begin
            sum_d   = sum_q + {8'h00, data_byte_i};
            phase_d = PH_LEN_HI;
          end else if (data_byte_i == StartA) begin
            sum_d = {8'h00, StartA};
          end else begin
            phase_d = PH_HUNT_A;
          end
        end
        PH_LEN_HI: begin
          sum_d    = sum_q + {8'h00, data_byte_i};
          len_hi_d = data_byte_i;
          phase_d  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          sum_d = sum_q + {8'h00, data_byte_i};
          if (!len_ok) begin
            // bad length: single error result, back to hunting
            out_valid_d  = 1'b1;
            out_status_d = ST_BADLEN;
            out_idx_d    = '0;
            out_value_d  = '0;
            out_last_d   = 1'b1;
            phase_d      = PH_HUNT_A;
          end else begin
            data_len_d = 6'(data_byte_i - 8'd2);
            byte_cnt_d = '0;
            phase_d    = (data_byte_i == 8'd2) ? PH_CHK_HI : PH_DATA;
          end
        end
        PH_DATA: begin
          sum_d      = sum_q + {8'h00, data_byte_i};
          byte_cnt_d = byte_cnt_q + 6'd1;
          if (!byte_cnt_q[0]) begin
            hi_byte_d = data_byte_i;
            // odd final byte goes out in the high half
            if (last_byte) begin
              ram_we    = 1'b1;
              ram_wdata = {data_byte_i, 8'h00};
            end
          end else begin
            ram_we = 1'b1;
          end
          if (last_byte) begin
            phase_d = PH_CHK_HI;
          end
        end
        PH_CHK_HI: begin
          chk_hi_d = data_byte_i;
          phase_d  = PH_CHK_LO;
        end
        PH_CHK_LO: begin
          phase_d = PH_HUNT_A;
          if ({chk_hi_q, data_byte_i} == sum_q) begin
            if (data_len_q != 6'd0) begin
              // start draining: prefetch word 0
              em_idx_d   = '0;
              em_words_d = words_sum[5:1];
              ram_re     = 1'b1;
              phase_d    = PH_EMIT;
            end
          end else begin
            out_valid_d  = 1'b1;
            out_status_d = ST_CSUM;
            out_idx_d    = '0;
            out_value_d  = '0;
            out_last_d   = 1'b1;
          end
        end
        default: begin
          // hunting the first start byte
          phase_d = PH_HUNT_A;
          if (data_byte_i == StartA) begin
            sum_d   = {8'h00, StartA};
            phase_d = PH_HUNT_B;
          end
        end
      endcase
    end

    // word output, one per cycle while the output register drains
    if (phase_q == PH_EMIT && out_free) begin
      out_valid_d  = 1'b1;
      out_status_d = ST_WORD;
      out_idx_d    = em_idx_q;
      out_value_d  = ram_rdata;
      out_last_d   = em_last;
      if (em_last) begin
        phase_d = PH_HUNT_A;
      end else begin
        em_idx_d  = em_idx_q + 4'd1;
        ram_re    = 1'b1;
        ram_raddr = WordAw'(em_idx_q + 4'd1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT_A;
      max_len_q   <= 6'd28;
      sum_q       <= '0;
      chk_hi_q    <= '0;
      len_hi_q    <= '0;
      data_len_q  <= '0;
      byte_cnt_q  <= '0;
      em_idx_q    <= '0;
      em_words_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
      sum_q       <= sum_d;
      chk_hi_q    <= chk_hi_d;
      len_hi_q    <= len_hi_d;
      data_len_q  <= data_len_d;
      byte_cnt_q  <= byte_cnt_d;
      em_idx_q    <= em_idx_d;
      em_words_q  <= em_words_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    hi_byte_q    <= hi_byte_d;
    out_status_q <= out_status_d;
    out_idx_q    <= out_idx_d;
    out_value_q  <= out_value_d;
    out_last_q   <= out_last_d;
  end

  sfp_word_ram u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign word_index_o = out_idx_q;
  assign word_value_o = out_value_q;
  assign last_o       = out_last_q;

  // no byte taken while words drain
  a_emit_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_EMIT) |-> in_stall_o)
    else $error("byte accepted during word output");

  // drain index stays inside the frame
  a_emit_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_EMIT) |-> ({1'b0, em_idx_q} < em_words_q))
    else $error("word index past frame end");

  // data phase never runs past the length field
  a_data_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (byte_cnt_q < data_len_q))
    else $error("data byte count overrun");

  // error results are single and last
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_WORD) |-> (last_o && word_index_o == 4'd0))
    else $error("error result not flagged last");

endmodule

[dv/sensor_frame_parser_core_tb.sv]
// testbench for sensor_frame_parser_core: serial bytes in, parsed data words and errors out
// depends on sfp_pkg and the design sources; self-checking against an in-bench parser model

`timescale 1ns / 1ps

module sensor_frame_parser_core_tb;
  import sfp_pkg::*;

  // one result item as the block presents it
  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  index;
    logic [15:0] value;
    logic        is_last;
  } parse_res_t;

  // how a directed byte is checked: by the parser model, or by a typed-in outcome
  typedef enum logic [1:0] {ROW_PREDICT, ROW_NONE, ROW_CSUM, ROW_BADLEN} row_kind_e;

  typedef struct packed {
    logic [7:0] data;
    row_kind_e  kind;
  } stim_row_t;

  // idle cycles after the last expected result before touching max_length
  localparam int QuietCycles   = 8;
  localparam int DrainCycles   = 20;
  localparam int BytesPerPhase = 20;
  // max_length plan for the random phases, the last phase picks a random value
  localparam logic [4:0][5:0] CfgPlan = {6'd2, 6'd34, 6'd0, 6'd63, 6'd1};

  logic        clk_i;
  logic        rst_ni       = 1'b0;
  logic        cfg_we_i     = 1'b0;
  logic [5:0]  cfg_wdata_i  = 6'd0;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i  = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic [1:0]  status_o;
  logic [3:0]  word_index_o;
  logic [15:0] word_value_o;
  logic        last_o;

  // parser model state
  logic [2:0]  prs_phase;
  logic [15:0] run_sum;
  logic [15:0] rx_check;
  logic [7:0]  len_hi;
  logic [5:0]  data_len;
  logic [5:0]  byte_cnt;
  logic [5:0]  max_len;
  logic [7:0]  frame_bytes [BufBytes];

  parse_res_t  step_res [$];   // results caused by the byte just parsed
  parse_res_t  parsed_q [$];   // results still owed by the block, oldest first
  parse_res_t  mon_got;
  parse_res_t  mon_want;

  int send_idle  = 34;
  int recv_idle  = 77;
  int bytes_sent = 0;
  int mismatches = 0;

  // directed bytes: restart on a repeated first start byte, nonzero length high byte,
  // wrong second byte, length below two, empty frame with a bad checksum,
  // and a good frame with all-ones, all-zeros and an odd trailing byte
  stim_row_t dir_rows [28] = '{
    '{8'h42, ROW_NONE}, '{8'h42, ROW_NONE}, '{8'h4D, ROW_NONE}, '{8'h01, ROW_NONE},
    '{8'h00, ROW_BADLEN},
    '{8'h42, ROW_NONE}, '{8'h13, ROW_NONE},
    '{8'h42, ROW_NONE}, '{8'h4D, ROW_NONE}, '{8'h00, ROW_NONE}, '{8'h01, ROW_BADLEN},
    '{8'h42, ROW_NONE}, '{8'h4D, ROW_NONE}, '{8'h00, ROW_NONE}, '{8'h02, ROW_NONE},
    '{8'h00, ROW_NONE}, '{8'h00, ROW_CSUM},
    '{8'h42, ROW_NONE}, '{8'h4D, ROW_NONE}, '{8'h00, ROW_NONE}, '{8'h07, ROW_NONE},
    '{8'hFF, ROW_NONE}, '{8'hFF, ROW_NONE}, '{8'h00, ROW_NONE}, '{8'h00, ROW_NONE},
    '{8'h80, ROW_NONE}, '{8'h03, ROW_NONE}, '{8'h14, ROW_PREDICT}
  };

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  sensor_frame_parser_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .word_index_o (word_index_o),
    .word_value_o (word_value_o),
    .last_o       (last_o)
  );

  // parser model: advances the state by one byte, fills step_res
  task automatic parse_byte(input logic [7:0] b);
    logic [15:0] len_field;
    logic [5:0]  lim;
    logic [15:0] w_val;
    int          n_words;
    int          hi_pos;
    step_res.delete();
    case (prs_phase)
      PH_HUNT_B: begin
        if (b == StartB) begin
          run_sum   = run_sum + 16'(b);
          prs_phase = PH_LEN_HI;
        end else if (b == StartA) begin
          // a repeated first start byte begins the frame again
          run_sum = 16'(StartA);
        end else begin
          prs_phase = PH_HUNT_A;
        end
      end
      PH_LEN_HI: begin
        run_sum   = run_sum + 16'(b);
        len_hi    = b;
        prs_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_field = {len_hi, b};
        run_sum   = run_sum + 16'(b);
        lim       = (max_len > LenCap) ? LenCap : max_len;
        if (len_field < 16'd2 || len_field > {10'd0, lim}) begin
          step_res.push_back(parse_res_t'{ST_BADLEN, 4'd0, 16'd0, 1'b1});
          prs_phase = PH_HUNT_A;
        end else begin
          data_len  = 6'(len_field - 16'd2);
          byte_cnt  = 6'd0;
          // length two has no data bytes, straight to the checksum
          prs_phase = (data_len != 6'd0) ? PH_DATA : PH_CHK_HI;
        end
      end
      PH_DATA: begin
        run_sum = run_sum + 16'(b);
        if (byte_cnt < data_len && int'(byte_cnt) < BufBytes) begin
          frame_bytes[byte_cnt] = b;
          byte_cnt = byte_cnt + 6'd1;
        end
        if (byte_cnt >= data_len || int'(byte_cnt) >= BufBytes) prs_phase = PH_CHK_HI;
      end
      PH_CHK_HI: begin
        rx_check  = {b, 8'h00};
        prs_phase = PH_CHK_LO;
      end
      PH_CHK_LO: begin
        rx_check[7:0] = b;
        prs_phase     = PH_HUNT_A;
        if (rx_check == run_sum) begin
          n_words = (int'(data_len) + 1) / 2;
          if (n_words > 16) n_words = 16;
          for (int w = 0; w < n_words; w++) begin
            hi_pos = 2 * w;
            w_val  = 16'h0000;
            if (hi_pos < int'(data_len) && hi_pos < BufBytes) w_val[15:8] = frame_bytes[hi_pos];
            if (hi_pos + 1 < int'(data_len) && hi_pos + 1 < BufBytes) begin
              w_val[7:0] = frame_bytes[hi_pos + 1];
            end
            step_res.push_back(parse_res_t'{ST_WORD, 4'(w), w_val, (w + 1 == n_words)});
          end
        end else begin
          step_res.push_back(parse_res_t'{ST_CSUM, 4'd0, 16'd0, 1'b1});
        end
      end
      default: begin
        prs_phase = PH_HUNT_A;
        if (b == StartA) begin
          run_sum   = 16'(StartA);
          prs_phase = PH_HUNT_B;
        end
      end
    endcase
  endtask

  // offers one byte with random gaps ahead of it, returns at the accepting edge
  task automatic push_byte(input logic [7:0] b, input row_kind_e kind = ROW_PREDICT);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    parse_byte(b);
    case (kind)
      ROW_PREDICT: foreach (step_res[k]) parsed_q.push_back(step_res[k]);
      ROW_CSUM:    parsed_q.push_back(parse_res_t'{ST_CSUM, 4'd0, 16'd0, 1'b1});
      ROW_BADLEN:  parsed_q.push_back(parse_res_t'{ST_BADLEN, 4'd0, 16'd0, 1'b1});
      default: ;
    endcase
    bytes_sent++;
  endtask

  // brings the parser back to hunting, lets it go quiet, then writes max_length
  task automatic write_max_length(input logic [5:0] val);
    while (prs_phase != PH_HUNT_A) push_byte(8'h00);
    in_valid_i <= 1'b0;
    while (parsed_q.size() != 0) @(posedge clk_i);
    repeat (QuietCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    max_len = val;
  endtask

  // one random stretch of stream: mostly whole frames, some broken ones and noise
  task automatic send_sequence();
    int          pick;
    int          lim;
    int          len;
    int          n_data;
    int          hi_cap;
    logic [15:0] csum;
    logic [7:0]  d;
    lim  = (max_len > LenCap) ? int'(LenCap) : int'(max_len);
    pick = $urandom_range(0, 9);
    if (pick <= 5 || pick == 9) begin
      // mostly short frames, now and then one at the full limit
      if (lim < 2) begin
        len = $urandom_range(2, 6);
      end else if ($urandom_range(0, 7) == 0) begin
        len = lim;
      end else begin
        hi_cap = (lim < 12) ? lim : 12;
        len    = $urandom_range(2, hi_cap);
      end
      n_data = len - 2;
      // truncated frame: whatever follows gets swallowed as data
      if (pick == 9) n_data = $urandom_range(0, n_data);
      csum = 16'(StartA) + 16'(StartB) + 16'(len);
      push_byte(StartA);
      push_byte(StartB);
      push_byte(8'h00);
      push_byte(8'(len));
      for (int k = 0; k < n_data; k++) begin
        d    = 8'($urandom);
        csum = csum + 16'(d);
        push_byte(d);
      end
      if (pick != 9) begin
        if ($urandom_range(0, 6) == 0) csum = csum ^ (16'd1 << $urandom_range(0, 15));
        push_byte(csum[15:8]);
        push_byte(csum[7:0]);
      end
    end else if (pick == 6) begin
      // bad length: nonzero high byte, below two, or above the limit
      push_byte(StartA);
      push_byte(StartB);
      case ($urandom_range(0, 2))
        0: begin
          push_byte(8'($urandom_range(1, 255)));
          push_byte(8'($urandom));
        end
        1: begin
          push_byte(8'h00);
          push_byte(8'($urandom_range(0, 1)));
        end
        default: begin
          push_byte(8'h00);
          push_byte(8'($urandom_range(lim + 1, 255)));
        end
      endcase
    end else if (pick == 7) begin
      // broken start pair
      push_byte(StartA);
      push_byte(($urandom_range(0, 1) == 1) ? StartA : 8'($urandom));
    end else begin
      repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
    end
  endtask

  // result side: random stall, every accepted item checked against the oldest owed one
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        mon_got = parse_res_t'{status_o, word_index_o, word_value_o, last_o};
        if (parsed_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected item: status %0d index %0d value %h last %0b",
                     mon_got.status, mon_got.index, mon_got.value, mon_got.is_last);
          end
        end else begin
          mon_want = parsed_q.pop_front();
          if (mon_got !== mon_want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display({"mismatch: expected status %0d index %0d value %h last %0b,",
                        " got %0d %0d %h %0b"},
                       mon_want.status, mon_want.index, mon_want.value, mon_want.is_last,
                       mon_got.status, mon_got.index, mon_got.value, mon_got.is_last);
            end
          end
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_idle);
    end
  end

  initial begin
    logic [5:0] cfg_val;
    int         start_cnt;
    prs_phase = PH_HUNT_A;
    run_sum   = 16'd0;
    rx_check  = 16'd0;
    len_hi    = 8'd0;
    data_len  = 6'd0;
    byte_cnt  = 6'd0;
    max_len   = 6'd28;
    foreach (frame_bytes[k]) frame_bytes[k] = 8'h00;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed bytes under the reset limit
    foreach (dir_rows[r]) push_byte(dir_rows[r].data, dir_rows[r].kind);

    // random phases: receiver-heavy idling, then sender-heavy, then none
    for (int p = 0; p < 6; p++) begin
      cfg_val = (p == 5) ? 6'($urandom_range(3, 33)) : CfgPlan[p];
      write_max_length(cfg_val);
      case (p / 2)
        0: begin send_idle = 34; recv_idle = 77; end
        1: begin send_idle = 77; recv_idle = 34; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      start_cnt = bytes_sent;
      while (bytes_sent - start_cnt < BytesPerPhase) send_sequence();
    end

    in_valid_i <= 1'b0;
    while (parsed_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && parsed_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // hard stop, well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

[filelist.f]
design/sfp_pkg.sv
design/sfp_word_ram.sv
design/sensor_frame_parser_core.sv
dv/sensor_frame_parser_core_tb.sv
